@@ sv/hsv2rgb_pkg.sv @@
// shared constants, types and divider reciprocals for the hsv to rgb converter
package hsv2rgb_pkg;

	localparam int HUE_FRAC_BITS = 6;

	localparam int HUE_W  = 16;
	localparam int SAT_W  = 8;
	localparam int VAL_W  = 8;
	localparam int CH_W   = 8;
	localparam int PACK_W = 25;

	localparam int CH_MAX  = 255;
	localparam int SECTORS = 6;

	// one 60 degree sector in hue units
	localparam int SPAN   = 60 << HUE_FRAC_BITS;
	localparam int REM_W  = $clog2(SPAN);
	localparam int SPAN_W = $clog2(SPAN + 1);

	// hue / SPAN quotient range
	localparam int QD_MAX = ((1 << HUE_W) - 1) / SPAN;
	localparam int QD_W   = $clog2(QD_MAX + 1);

	// x / d = (x * ceil(2^k / d)) >> k, exact for x < 2^n when k = n + clog2(d)
	localparam int          HQ_K = HUE_W + $clog2(SPAN);
	localparam logic [63:0] HQ_M = ((64'd1 << HQ_K) + 64'(SPAN) - 64'd1) / 64'(SPAN);
	localparam int          HQ_P = HQ_K + QD_W;

	localparam int          K6 = QD_W + $clog2(SECTORS);
	localparam logic [63:0] M6 = ((64'd1 << K6) + 64'(SECTORS) - 64'd1) / 64'(SECTORS);
	localparam int          P6 = K6 + QD_W;

	localparam int          PN_W = SAT_W + VAL_W;
	localparam int          KP   = PN_W + $clog2(CH_MAX);
	localparam logic [63:0] MP   = ((64'd1 << KP) + 64'(CH_MAX) - 64'd1) / 64'(CH_MAX);
	localparam int          PP   = KP + CH_W;

	localparam int          DEN   = CH_MAX * SPAN;
	localparam int          DEN_W = $clog2(DEN + 1);
	localparam int          X_W   = VAL_W + DEN_W;
	localparam int          KD    = X_W + $clog2(DEN);
	localparam logic [63:0] MD    = ((64'd1 << KD) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam int          PD    = KD + CH_W;

	// cycles from accepted word to result strobe
	localparam int LATENCY = 7;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic             valid;
		sector_t          sector;
		logic [REM_W-1:0] rem;
		logic [SAT_W-1:0] sat;
		logic [VAL_W-1:0] val;
	} hue_split_t;

	typedef struct packed {
		logic            valid;
		sector_t         sector;
		logic            grey;
		logic [CH_W-1:0] v;
		logic [CH_W-1:0] p;
		logic [CH_W-1:0] q;
		logic [CH_W-1:0] t;
	} chan_terms_t;

endpackage

@@ sv/hsv2rgb_sector.sv @@
// stages 1-3: hue reduced to a sector index and remainder within the sector
module hsv2rgb_sector import hsv2rgb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [HUE_W-1:0] hue,
	input  logic [SAT_W-1:0] saturation,
	input  logic [VAL_W-1:0] brightness,
	output hue_split_t       split
);

	logic [HQ_P-1:0]   hq_prod;
	logic              valid_s1;
	logic [HUE_W-1:0]  hue_s1;
	logic [SAT_W-1:0]  sat_s1;
	logic [VAL_W-1:0]  val_s1;
	logic [QD_W-1:0]   qd_s1;

	logic [P6-1:0]     q6_prod;
	logic [HUE_W-1:0]  rem_full;
	logic              valid_s2;
	logic [REM_W-1:0]  rem_s2;
	logic [QD_W-1:0]   qd_s2;
	logic [QD_W-1:0]   qd6_s2;
	logic [SAT_W-1:0]  sat_s2;
	logic [VAL_W-1:0]  val_s2;

	logic [QD_W+2:0]   sec_full;
	logic              valid_s3;
	sector_t           sector_s3;
	logic [REM_W-1:0]  rem_s3;
	logic [SAT_W-1:0]  sat_s3;
	logic [VAL_W-1:0]  val_s3;

	// quotient of hue by one sector span
	assign hq_prod  = HQ_P'(hue) * HQ_P'(HQ_M);
	assign rem_full = hue_s1 - HUE_W'(qd_s1) * HUE_W'(SPAN);
	// quotient of sector count by six, for the wrap at a full turn
	assign q6_prod  = P6'(qd_s1) * P6'(M6);
	assign sec_full = (QD_W+3)'(qd_s2) - (QD_W+3)'(qd6_s2) * (QD_W+3)'(SECTORS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		hue_s1    <= hue;
		sat_s1    <= saturation;
		val_s1    <= brightness;
		qd_s1     <= hq_prod[HQ_K +: QD_W];

		rem_s2    <= rem_full[REM_W-1:0];
		qd_s2     <= qd_s1;
		qd6_s2    <= q6_prod[K6 +: QD_W];
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;

		sector_s3 <= sector_t'(sec_full[2:0]);
		rem_s3    <= rem_s2;
		sat_s3    <= sat_s2;
		val_s3    <= val_s2;
	end

	assign split.valid  = valid_s3;
	assign split.sector = sector_s3;
	assign split.rem    = rem_s3;
	assign split.sat    = sat_s3;
	assign split.val    = val_s3;

endmodule

@@ sv/hsv2rgb_terms.sv @@
// stages 4-6: p, q and t terms by reciprocal division
module hsv2rgb_terms import hsv2rgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hue_split_t  split,
	output chan_terms_t terms
);

	logic [SPAN_W-1:0] span_left;
	logic [SAT_W-1:0]  sat_left;
	logic              valid_s4;
	logic [DEN_W-1:0]  aq_s4;
	logic [DEN_W-1:0]  at_s4;
	logic [PN_W-1:0]   pnum_s4;
	sector_t           sector_s4;
	logic              grey_s4;
	logic [VAL_W-1:0]  val_s4;

	logic [PP-1:0]     p_prod;
	logic              valid_s5;
	logic [X_W-1:0]    xq_s5;
	logic [X_W-1:0]    xt_s5;
	logic [CH_W-1:0]   p_s5;
	sector_t           sector_s5;
	logic              grey_s5;
	logic [VAL_W-1:0]  val_s5;

	logic [PD-1:0]     q_prod;
	logic [PD-1:0]     t_prod;
	logic              valid_s6;
	logic [CH_W-1:0]   q_s6;
	logic [CH_W-1:0]   t_s6;
	logic [CH_W-1:0]   p_s6;
	sector_t           sector_s6;
	logic              grey_s6;
	logic [VAL_W-1:0]  val_s6;

	assign span_left = SPAN_W'(SPAN) - SPAN_W'(split.rem);
	assign sat_left  = SAT_W'(CH_MAX) - split.sat;
	assign p_prod    = PP'(pnum_s4) * PP'(MP);
	assign q_prod    = PD'(xq_s5) * PD'(MD);
	assign t_prod    = PD'(xt_s5) * PD'(MD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= split.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		aq_s4     <= DEN_W'(split.sat) * DEN_W'(split.rem);
		at_s4     <= DEN_W'(split.sat) * DEN_W'(span_left);
		pnum_s4   <= PN_W'(split.val) * PN_W'(sat_left);
		sector_s4 <= split.sector;
		grey_s4   <= (split.sat == '0);
		val_s4    <= split.val;

		// numerators over the common denominator 255 * span
		xq_s5     <= X_W'(val_s4) * X_W'(DEN_W'(DEN) - aq_s4);
		xt_s5     <= X_W'(val_s4) * X_W'(DEN_W'(DEN) - at_s4);
		p_s5      <= p_prod[KP +: CH_W];
		sector_s5 <= sector_s4;
		grey_s5   <= grey_s4;
		val_s5    <= val_s4;

		q_s6      <= q_prod[KD +: CH_W];
		t_s6      <= t_prod[KD +: CH_W];
		p_s6      <= p_s5;
		sector_s6 <= sector_s5;
		grey_s6   <= grey_s5;
		val_s6    <= val_s5;
	end

	assign terms.valid  = valid_s6;
	assign terms.sector = sector_s6;
	assign terms.grey   = grey_s6;
	assign terms.v      = CH_W'(val_s6);
	assign terms.p      = p_s6;
	assign terms.q      = q_s6;
	assign terms.t      = t_s6;

endmodule

@@ sv/hsv2rgb_mux.sv @@
// stage 7: channel selection by sector and registered result word
module hsv2rgb_mux import hsv2rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  chan_terms_t       terms,
	output logic              done,
	output logic [CH_W-1:0]   red,
	output logic [CH_W-1:0]   green,
	output logic [CH_W-1:0]   blue,
	output logic [PACK_W-1:0] packed_color
);

	logic [CH_W-1:0] r_sel;
	logic [CH_W-1:0] g_sel;
	logic [CH_W-1:0] b_sel;
	logic            done_s7;
	logic [CH_W-1:0] red_s7;
	logic [CH_W-1:0] green_s7;
	logic [CH_W-1:0] blue_s7;

	always_comb begin
		r_sel = terms.v;
		g_sel = terms.p;
		b_sel = terms.q;
		if (terms.grey) begin
			r_sel = terms.v;
			g_sel = terms.v;
			b_sel = terms.v;
		end else begin
			unique case (terms.sector)
				SEC_RED_YEL: begin
					r_sel = terms.v; g_sel = terms.t; b_sel = terms.p;
				end
				SEC_YEL_GRN: begin
					r_sel = terms.q; g_sel = terms.v; b_sel = terms.p;
				end
				SEC_GRN_CYN: begin
					r_sel = terms.p; g_sel = terms.v; b_sel = terms.t;
				end
				SEC_CYN_BLU: begin
					r_sel = terms.p; g_sel = terms.q; b_sel = terms.v;
				end
				SEC_BLU_MAG: begin
					r_sel = terms.t; g_sel = terms.p; b_sel = terms.v;
				end
				SEC_MAG_RED: begin
					r_sel = terms.v; g_sel = terms.p; b_sel = terms.q;
				end
				default: begin
					r_sel = terms.v; g_sel = terms.p; b_sel = terms.q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= terms.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_s7   <= r_sel;
		green_s7 <= g_sel;
		blue_s7  <= b_sel;
	end

	assign done         = done_s7;
	assign red          = red_s7;
	assign green        = green_s7;
	assign blue         = blue_s7;
	assign packed_color = {1'b1, blue_s7, green_s7, red_s7};

endmodule

@@ sv/hsv_to_rgb_color_pack_core.sv @@
// top level of the hsv to rgb converter with packed color word
//
//   channel  | handshake      | fields
//   ---------+----------------+--------------------------------------
//   input    | start / busy   | hue[15:0] saturation[7:0] brightness[7:0]
//   result   | done (strobe)  | red[7:0] green[7:0] blue[7:0] packed_color[24:0]
//
// one word per clock; busy stays low, so a word may be started every cycle
// done is high in the cycle after the 7th register stage loads, and the result
// passes through one register per pipeline stage from the accepting edge
// asynchronous reset clears the valid bits of all seven stages at once
// the result side has no stall; every result is shown for exactly one cycle
module hsv_to_rgb_color_pack_core import hsv2rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [HUE_W-1:0]  hue,
	input  logic [SAT_W-1:0]  saturation,
	input  logic [VAL_W-1:0]  brightness,
	output logic              done,
	output logic [CH_W-1:0]   red,
	output logic [CH_W-1:0]   green,
	output logic [CH_W-1:0]   blue,
	output logic [PACK_W-1:0] packed_color
);

	logic        accept;
	hue_split_t  split;
	chan_terms_t terms;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hsv2rgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.split      (split)
	);

	hsv2rgb_terms u_terms (
		.clk    (clk),
		.arst_n (arst_n),
		.split  (split),
		.terms  (terms)
	);

	hsv2rgb_mux u_mux (
		.clk          (clk),
		.arst_n       (arst_n),
		.terms        (terms),
		.done         (done),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.packed_color (packed_color)
	);

endmodule

@@ sv/hsv2rgb_checker.sv @@
// port level checks for the hsv to rgb converter, bound to the top level
module hsv2rgb_checker import hsv2rgb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [CH_W-1:0]   red,
	input logic [CH_W-1:0]   green,
	input logic [CH_W-1:0]   blue,
	input logic [PACK_W-1:0] packed_color
);

	// every started word gives a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("started word gave no result");

	// no result without a started word
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a started word");

	// packed word agrees with the separate channels
	a_packing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (packed_color[24] && packed_color[7:0] == red &&
			packed_color[15:8] == green && packed_color[23:16] == blue))
		else $error("packed color does not match channels");

	// the pipeline never refuses a word
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind hsv_to_rgb_color_pack_core hsv2rgb_checker u_checker (.*);

@@ sim/tb.sv @@
// testbench for the hsv to rgb converter: queued hsv words against a predicted color word
`timescale 1ns / 1ps

module tb;
	import hsv2rgb_pkg::*;

	typedef struct {
		logic [HUE_W-1:0] h;
		logic [SAT_W-1:0] s;
		logic [VAL_W-1:0] v;
		int               idle_pct;
	} hsv_word_t;

	typedef struct {
		logic [CH_W-1:0]   r;
		logic [CH_W-1:0]   g;
		logic [CH_W-1:0]   b;
		logic [PACK_W-1:0] pk;
	} rgb_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [HUE_W-1:0]  hue = '0;
	logic [SAT_W-1:0]  saturation = '0;
	logic [VAL_W-1:0]  brightness = '0;
	logic              done;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic [PACK_W-1:0] packed_color;

	hsv_word_t hsv_backlog[$];
	rgb_word_t rgb_pending[$];
	int        fault_count = 0;

	hsv_to_rgb_color_pack_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.hue          (hue),
		.saturation   (saturation),
		.brightness   (brightness),
		.done         (done),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.packed_color (packed_color)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// exact integer form of the hsv conversion, channels rounded down
	function automatic rgb_word_t rgb_of_hsv(logic [HUE_W-1:0] h, logic [SAT_W-1:0] s,
			logic [VAL_W-1:0] v);
		longint unsigned hm, sec, rem, den, p, q, t, sat, val;
		rgb_word_t c;
		sat = s;
		val = v;
		hm  = longint'(h) % (SECTORS * SPAN);
		sec = hm / SPAN;
		rem = hm % SPAN;
		den = CH_MAX * SPAN;
		p   = (val * (CH_MAX - sat)) / CH_MAX;
		q   = (val * (den - sat * rem)) / den;
		t   = (val * (den - sat * (SPAN - rem))) / den;
		if (sat == 0) begin
			c.r = v; c.g = v; c.b = v;
		end else begin
			unique case (sector_t'(sec[2:0]))
				SEC_RED_YEL: begin c.r = v;     c.g = t[7:0]; c.b = p[7:0]; end
				SEC_YEL_GRN: begin c.r = q[7:0]; c.g = v;     c.b = p[7:0]; end
				SEC_GRN_CYN: begin c.r = p[7:0]; c.g = v;     c.b = t[7:0]; end
				SEC_CYN_BLU: begin c.r = p[7:0]; c.g = q[7:0]; c.b = v;     end
				SEC_BLU_MAG: begin c.r = t[7:0]; c.g = p[7:0]; c.b = v;     end
				default:     begin c.r = v;     c.g = p[7:0]; c.b = q[7:0]; end
			endcase
		end
		c.pk = {1'b1, c.b, c.g, c.r};
		return c;
	endfunction

	task automatic queue_hsv(int h, int s, int v, int idle_pct);
		hsv_word_t w;
		w.h = h[HUE_W-1:0];
		w.s = s[SAT_W-1:0];
		w.v = v[VAL_W-1:0];
		w.idle_pct = idle_pct;
		hsv_backlog.insert(hsv_backlog.size(), w);
	endtask

	// hues biased toward sector edges and full-turn wraps
	function automatic int pick_hue();
		int k;
		unique case ($urandom_range(5))
			0: begin
				k = $urandom_range(17);
				return k * SPAN + $urandom_range(3);
			end
			1: begin
				k = $urandom_range(1, 17);
				return k * SPAN - 1 - $urandom_range(2);
			end
			2: return $urandom_range(65535, 65500);
			default: return $urandom_range(65535);
		endcase
	endfunction

	function automatic int pick_byte();
		unique case ($urandom_range(7))
			0: return 0;
			1: return 255;
			2: return $urandom_range(3);
			default: return $urandom_range(255);
		endcase
	endfunction

	// driver: a word is taken at an edge with start high and busy low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				rgb_pending.insert(rgb_pending.size(),
					rgb_of_hsv(hue, saturation, brightness));
			if (!start || !busy) begin
				if (hsv_backlog.size() > 0 &&
						$urandom_range(99) >= hsv_backlog[0].idle_pct) begin
					start      <= 1'b1;
					hue        <= hsv_backlog[0].h;
					saturation <= hsv_backlog[0].s;
					brightness <= hsv_backlog[0].v;
					void'(hsv_backlog.pop_front());
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val !== act_val) begin
			fault_count++;
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, exp_val, act_val);
		end
	endtask

	// monitor: every strobed color word is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rgb_pending.size() == 0) begin
				fault_count++;
				$display("%0t: color word with none expected, got 0x%0h", $time,
					packed_color);
			end else begin
				check_field("red", rgb_pending[0].r, red);
				check_field("green", rgb_pending[0].g, green);
				check_field("blue", rgb_pending[0].b, blue);
				check_field("packed_color", rgb_pending[0].pk, packed_color);
				void'(rgb_pending.pop_front());
			end
		end
	end

	initial begin
		int phase_idle[4];
		int ph;
		int n;
		phase_idle = '{0, 46, 0, 21};

		// grey, every sector edge, wrap and the field extremes
		queue_hsv(0, 0, 0, 0);
		queue_hsv(12345, 0, 255, 0);
		queue_hsv(0, 0, 137, 0);
		for (n = 0; n < SECTORS; n++)
			queue_hsv(n * SPAN, 255, 255, 0);
		for (n = 1; n <= SECTORS; n++)
			queue_hsv(n * SPAN - 1, 255, 255, 0);
		queue_hsv(SECTORS * SPAN, 255, 200, 0);
		queue_hsv(SECTORS * SPAN + SPAN / 2, 128, 255, 0);
		queue_hsv(65535, 255, 255, 0);
		queue_hsv(65535, 1, 1, 0);
		queue_hsv(SPAN / 2, 255, 0, 0);
		queue_hsv(3 * SPAN + SPAN / 2, 1, 255, 0);
		queue_hsv(5 * SPAN + 1, 254, 254, 0);
		queue_hsv(65535 - SPAN, 170, 85, 0);

		for (ph = 0; ph < 4; ph++)
			for (n = 0; n < 163; n++)
				queue_hsv(pick_hue(), pick_byte(), pick_byte(), phase_idle[ph]);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (hsv_backlog.size() == 0);
		@(posedge clk);
		while (start) @(posedge clk);
		while (rgb_pending.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
